// ===== hdl/gcs_pkg.sv =====
// Package for the grapheme cluster segmenter: payload types, class codes, break rule function.
`default_nettype none
package gcs_pkg;

    // grapheme break classes
    localparam logic [3:0] C_OTHER   = 4'd0;
    localparam logic [3:0] C_CR      = 4'd1;
    localparam logic [3:0] C_LF      = 4'd2;
    localparam logic [3:0] C_CONTROL = 4'd3;
    localparam logic [3:0] C_EXTEND  = 4'd4;
    localparam logic [3:0] C_ZWJ     = 4'd5;
    localparam logic [3:0] C_RI      = 4'd6;
    localparam logic [3:0] C_PREPEND = 4'd7;
    localparam logic [3:0] C_SPACING = 4'd8;
    localparam logic [3:0] C_L       = 4'd9;
    localparam logic [3:0] C_V       = 4'd10;
    localparam logic [3:0] C_T       = 4'd11;
    localparam logic [3:0] C_LV      = 4'd12;
    localparam logic [3:0] C_LVT     = 4'd13;

    // Indic conjunct break classes
    localparam logic [1:0] INCB_NONE      = 2'd0;
    localparam logic [1:0] INCB_CONSONANT = 2'd1;
    localparam logic [1:0] INCB_EXTEND    = 2'd2;
    localparam logic [1:0] INCB_LINKER    = 2'd3;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [3:0] gcb_class;
        logic [1:0] conjunct_class;
        logic       pictographic;
        logic [2:0] byte_count;
        logic       end_of_text;
    } t_gcs_in;

    typedef struct packed {
        logic [31:0] clust_start;
        logic [31:0] cluster_length;
        logic        final_cluster;
    } t_gcs_out;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // classes above LVT fold to Other
    function automatic logic [3:0] norm_class(input logic [3:0] c);
        norm_class = (c > C_LVT) ? C_OTHER : c;
    endfunction

    function automatic logic is_control_like(input logic [3:0] c);
        is_control_like = (c == C_CR) || (c == C_LF) || (c == C_CONTROL);
    endfunction

    // break between previous class a and current class b
    function automatic logic is_boundary(
        input logic [3:0] a,
        input logic [3:0] b,
        input logic [1:0] incb,
        input logic       pict,
        input logic       conj_run,
        input logic       conj_linker,
        input logic       pict_zwj,
        input logic       ri_odd
    );
        priority if (a == C_CR && b == C_LF)
            is_boundary = 1'b0;
        else if (is_control_like(a) || is_control_like(b))
            is_boundary = 1'b1;
        else if (a == C_L && (b == C_L || b == C_V || b == C_LV || b == C_LVT))
            is_boundary = 1'b0;
        else if ((a == C_LV || a == C_V) && (b == C_V || b == C_T))
            is_boundary = 1'b0;
        else if ((a == C_LVT || a == C_T) && b == C_T)
            is_boundary = 1'b0;
        else if (b == C_EXTEND || b == C_ZWJ || b == C_SPACING)
            is_boundary = 1'b0;
        else if (a == C_PREPEND)
            is_boundary = 1'b0;
        else if (incb == INCB_CONSONANT && conj_run && conj_linker)
            is_boundary = 1'b0;
        else if (pict && pict_zwj)
            is_boundary = 1'b0;
        else if (a == C_RI && b == C_RI && ri_odd)
            is_boundary = 1'b0;
        else
            is_boundary = 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gcs_queue.sv =====
// Small FIFO of cluster entries between front and back.
`default_nettype none
module gcs_queue #(
    parameter int WIDTH = 130
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_wdata,
    input  wire logic               i_pop,
    output gcs_pkg::t_q_status      o_status,
    output logic [WIDTH-1:0]        o_rdata
);
    import gcs_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             full, empty, do_push, do_pop;

    assign full    = (r_cnt == CW'(Q_DEPTH));
    assign empty   = (r_cnt == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_status.full  = full;
    assign o_status.empty = empty;
    assign o_rdata        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && empty))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hdl/gcs_front.sv =====
// Front: accepts code points, applies the break rules and queues cluster offsets.
`default_nettype none
module gcs_front #(
    parameter int OFFSET_BITS = 32,
    parameter int ENTRY_W     = 130
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gcs_pkg::t_gcs_in   i_in_data,
    input  wire gcs_pkg::t_q_status i_q_status,
    output logic                    o_push,
    output logic [ENTRY_W-1:0]      o_entry
);
    import gcs_pkg::*;

    localparam int OB = OFFSET_BITS;

    typedef struct packed {
        logic          b_valid;
        logic [OB-1:0] b_start;
        logic [OB-1:0] b_end;
        logic          f_valid;
        logic [OB-1:0] f_start;
        logic [OB-1:0] f_end;
    } t_entry;

    logic [3:0]    r_prev_class;
    logic          r_have_prev, r_ri_odd, r_conj_run, r_conj_linker, r_pict_run, r_pict_zwj;
    logic [OB-1:0] r_start, r_pos;

    logic [3:0]    cls;
    logic [1:0]    incb;
    logic          accept, bnd;
    logic [OB:0]   pos_sum;
    logic [OB-1:0] n_pos, n_start;
    logic          n_conj_run, n_conj_linker;
    t_entry        entry;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign cls        = norm_class(i_in_data.gcb_class);
    assign incb       = i_in_data.conjunct_class;

    always_comb begin
        bnd = r_have_prev && is_boundary(r_prev_class, cls, incb, i_in_data.pictographic,
                                         r_conj_run, r_conj_linker, r_pict_zwj, r_ri_odd);
        // saturating byte position
        pos_sum = {1'b0, r_pos} + (OB+1)'(i_in_data.byte_count);
        n_pos   = pos_sum[OB] ? '1 : pos_sum[OB-1:0];
        n_start = bnd ? r_pos : r_start;

        n_conj_run    = r_conj_run;
        n_conj_linker = r_conj_linker;
        unique case (incb)
            INCB_CONSONANT: begin
                n_conj_run    = 1'b1;
                n_conj_linker = 1'b0;
            end
            INCB_LINKER: begin
                if (r_conj_run) n_conj_linker = 1'b1;
            end
            INCB_EXTEND: ;
            INCB_NONE: begin
                n_conj_run    = 1'b0;
                n_conj_linker = 1'b0;
            end
        endcase

        entry.b_valid = bnd;
        entry.b_start = r_start;
        entry.b_end   = r_pos;
        entry.f_valid = i_in_data.end_of_text;
        entry.f_start = n_start;
        entry.f_end   = n_pos;
    end

    assign o_push  = accept && (bnd || i_in_data.end_of_text);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class  <= C_OTHER;
            r_have_prev   <= 1'b0;
            r_ri_odd      <= 1'b0;
            r_conj_run    <= 1'b0;
            r_conj_linker <= 1'b0;
            r_pict_run    <= 1'b0;
            r_pict_zwj    <= 1'b0;
            r_start       <= '0;
            r_pos         <= '0;
        end else if (accept) begin
            if (i_in_data.end_of_text) begin
                // text done: next code point opens a new text at offset 0
                r_prev_class  <= C_OTHER;
                r_have_prev   <= 1'b0;
                r_ri_odd      <= 1'b0;
                r_conj_run    <= 1'b0;
                r_conj_linker <= 1'b0;
                r_pict_run    <= 1'b0;
                r_pict_zwj    <= 1'b0;
                r_start       <= '0;
                r_pos         <= '0;
            end else begin
                r_prev_class  <= cls;
                r_have_prev   <= 1'b1;
                r_ri_odd      <= (cls == C_RI) ? !r_ri_odd : 1'b0;
                r_conj_run    <= n_conj_run;
                r_conj_linker <= n_conj_linker;
                r_pict_zwj    <= (cls == C_ZWJ) && r_pict_run;
                if (cls != C_EXTEND) r_pict_run <= i_in_data.pictographic;
                r_start       <= n_start;
                r_pos         <= n_pos;
            end
        end
    end

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.end_of_text |=> !r_have_prev && (r_pos == '0))
        else $error("state not cleared after end of text");

endmodule
`default_nettype wire

// ===== hdl/gcs_back.sv =====
// Back: unpacks queue entries to cluster results in output reg, one per cycle unless stalled.
`default_nettype none
module gcs_back #(
    parameter int OFFSET_BITS = 32,
    parameter int ENTRY_W     = 130
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gcs_pkg::t_q_status i_q_status,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gcs_pkg::t_gcs_out       o_out_data
);
    import gcs_pkg::*;

    localparam int OB  = OFFSET_BITS;
    localparam int EXT = (OB >= 32) ? OB : 32;

    typedef struct packed {
        logic          b_valid;
        logic [OB-1:0] b_start;
        logic [OB-1:0] b_end;
        logic          f_valid;
        logic [OB-1:0] f_start;
        logic [OB-1:0] f_end;
    } t_entry;

    t_entry         head;
    logic           r_phase;   // boundary cluster of head already sent
    logic           r_valid;
    t_gcs_out       r_out;
    logic           load, sel_final, last;
    logic [OB-1:0]  sel_start, sel_end, diff;
    logic [EXT-1:0] ext_start, ext_len;

    assign head      = t_entry'(i_entry);
    assign load      = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign sel_final = r_phase || !head.b_valid;
    assign last      = sel_final || !head.f_valid;
    assign sel_start = sel_final ? head.f_start : head.b_start;
    assign sel_end   = sel_final ? head.f_end : head.b_end;
    assign diff      = sel_end - sel_start;
    assign ext_start = EXT'(sel_start);
    assign ext_len   = EXT'(diff);
    assign o_pop     = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !last;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.clust_start    <= ext_start[31:0];
            r_out.cluster_length <= ext_len[31:0];
            r_out.final_cluster  <= sel_final;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_q_status.empty && head.b_valid && head.f_valid)
        else $error("second half pending without a two-result entry");

endmodule
`default_nettype wire

// ===== hdl/grapheme_cluster_segmenter.sv =====
// Top level of the extended grapheme cluster segmenter.
// Path: the entry for the code point that closes a cluster is written into the queue,
//   then the back loads the cluster result from it into the output register.
// Throughput: one code point per cycle while the queue is not full; a code point that
//   yields two results (a boundary and end of text) sends them one after the other
//   through the single output register; the four-entry queue absorbs such bursts.
// Reset: synchronous active-low; clears run state, offsets, queue and output valid.
`default_nettype none
module grapheme_cluster_segmenter #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // code point channel
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire gcs_pkg::t_gcs_in i_in_data,
    // cluster result channel
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output gcs_pkg::t_gcs_out   o_out_data
);
    import gcs_pkg::*;

    // queue entry: boundary cluster (start, end) and final cluster (start, end)
    localparam int ENTRY_W = 2 + 4 * OFFSET_BITS;

    t_q_status          q_status;
    logic               push, pop;
    logic [ENTRY_W-1:0] wentry, rentry;

    // Front: break rules and offset tracking; a transfer in that closes a cluster
    // or ends the text pushes one entry.
    gcs_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (wentry)
    );

    // Queue decouples front stall from output stall.
    gcs_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (wentry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_rdata  (rentry)
    );

    // Back: computes lengths and sends one result transfer per cycle unless stalled.
    gcs_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_entry     (rentry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
